// File: hdl/wildcard_name_match_unit_macros.svh
// Assertion helpers for the wildcard name match unit.
// WNM_ASSERT_CLK names its clock and reset; WNM_ASSERT uses clk_i and rst_ni.
`ifndef WILDCARD_NAME_MATCH_UNIT_MACROS_SVH
`define WILDCARD_NAME_MATCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WNM_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WNM_ASSERT(label, prop, msg) \
  `WNM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define WNM_ASSERT_CLK(label, clk, rstn, prop, msg)
`define WNM_ASSERT(label, prop, msg)
`endif

`endif

// File: hdl/wnm_pkg.sv
`default_nettype none
package wnm_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_NAME   = 2'd2,
    FUNC_EMPTY  = 2'd3
  } func_e;

  // Pattern and folding constants
  localparam logic [7:0] STAR_CH   = 8'h2A;
  localparam logic [7:0] ANY_CH    = 8'h3F;
  localparam logic [7:0] LOW_A     = 8'h61;
  localparam logic [7:0] LOW_Z     = 8'h7A;
  localparam logic [7:0] CASE_MASK = 8'h5F;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_FOLD_LOWER_A = 2'd0;
  localparam logic [1:0] REG_FOLD_LOWER_B = 2'd1;
  localparam logic [1:0] REG_FOLD_UPPER_A = 2'd2;
  localparam logic [1:0] REG_FOLD_UPPER_B = 2'd3;

  typedef struct packed {
    logic [63:0] lower_a;
    logic [63:0] lower_b;
    logic [63:0] upper_a;
    logic [63:0] upper_b;
  } fold_cfg_t;

  // One registered item; ch is already case-folded for name chars
  typedef struct packed {
    func_e      func;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic emit;
    logic matched;
    logic overflow;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/wnm_fold.sv
`default_nettype none
module wnm_fold (
  input  wnm_pkg::fold_cfg_t cfg_i,
  input  logic [7:0]         ch_i,
  output logic [7:0]         ch_o
);

  logic [127:0] lower;
  logic [127:0] upper;
  logic [7:0]   tbl_ch;

  assign lower = {cfg_i.lower_b, cfg_i.lower_a};
  assign upper = {cfg_i.upper_b, cfg_i.upper_a};

  // Accent table lookup: scan high to low so the lowest entry wins
  always_comb begin
    tbl_ch = ch_i;
    for (int k = 15; k >= 0; k--) begin
      if (lower[k*8 +: 8] != 8'h00 && lower[k*8 +: 8] == ch_i) begin
        tbl_ch = upper[k*8 +: 8];
      end
    end
  end

  // a-z fold by mask, above z through the table
  always_comb begin
    if (ch_i < wnm_pkg::LOW_A) begin
      ch_o = ch_i;
    end else if (ch_i <= wnm_pkg::LOW_Z) begin
      ch_o = ch_i & wnm_pkg::CASE_MASK;
    end else begin
      ch_o = tbl_ch;
    end
  end

endmodule
`default_nettype wire

// File: hdl/wnm_nfa.sv
`default_nettype none
module wnm_nfa #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wnm_pkg::item_t      item_i,
  output wnm_pkg::res_t       res_o
);

  localparam int W    = PATTERN_MAX + 1;
  localparam int LenW = $clog2(PATTERN_MAX + 1);

  // Pattern bytes, one lane per position; no reset, only read below length
  logic [7:0]      store_q [PATTERN_MAX];

  logic [LenW-1:0] len_q, len_d;
  logic            too_long_q, too_long_d;
  logic [W-1:0]    active_q, active_d;
  logic [W-1:0]    start_q, start_d;
  logic            busy_q, busy_d;

  logic                   full;
  logic [PATTERN_MAX-1:0] star_m;
  logic [PATTERN_MAX-1:0] step_m;
  logic [W-1:0]           cur_set;
  logic [W-1:0]           nxt_set;
  logic [W-1:0]           star_s;
  logic [W-1:0]           star_x;
  logic [W-1:0]           closed;
  logic [W-1:0]           start_ext;
  logic                   hit_name;
  logic                   hit_empty;

  assign full = (len_q == LenW'(PATTERN_MAX));

  // Per-lane decode of the stored pattern
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star_m[i] = (LenW'(i) < len_q) && (store_q[i] == wnm_pkg::STAR_CH);
      step_m[i] = (LenW'(i) < len_q) &&
                  ((store_q[i] == wnm_pkg::ANY_CH) || (store_q[i] == item_i.ch));
    end
  end

  // Start set of a name unless one is in progress
  assign cur_set = busy_q ? active_q : start_q;

  // Advance all active positions by one character
  always_comb begin
    nxt_set = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (cur_set[i] && star_m[i]) begin
        nxt_set[i] = 1'b1;
      end else if (cur_set[i] && step_m[i]) begin
        nxt_set[i+1] = 1'b1;
      end
    end
  end

  // Star closure: an active star passes through its whole run of stars.
  // The add ripples a carry from each active star to one past the run end.
  assign star_s = {1'b0, star_m};
  assign star_x = nxt_set & star_s;
  assign closed = nxt_set | ((star_s + star_x) ^ star_s);

  assign hit_name  = closed[len_q];
  assign hit_empty = start_q[len_q];

  // Start set grows by one when a star is appended at a reachable position
  assign start_ext = (!full && start_q[len_q] && item_i.ch == wnm_pkg::STAR_CH)
                     ? ((W'(1) << len_q) << 1) : '0;

  // Next state per item kind
  always_comb begin
    len_d      = len_q;
    too_long_d = too_long_q;
    active_d   = active_q;
    start_d    = start_q;
    busy_d     = busy_q;
    case (item_i.func)
      wnm_pkg::FUNC_CLEAR: begin
        len_d      = '0;
        too_long_d = 1'b0;
        active_d   = '0;
        start_d    = W'(1);
        busy_d     = 1'b0;
      end
      wnm_pkg::FUNC_APPEND: begin
        active_d = '0;
        busy_d   = 1'b0;
        if (full) begin
          too_long_d = 1'b1;
        end else begin
          len_d   = len_q + LenW'(1);
          start_d = start_q | start_ext;
        end
      end
      wnm_pkg::FUNC_NAME: begin
        active_d = closed;
        busy_d   = !item_i.last;
      end
      default: begin
        active_d = start_q;
        busy_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      too_long_q <= 1'b0;
      active_q   <= '0;
      start_q    <= W'(1);
      busy_q     <= 1'b0;
    end else if (step_i) begin
      len_q      <= len_d;
      too_long_q <= too_long_d;
      active_q   <= active_d;
      start_q    <= start_d;
      busy_q     <= busy_d;
    end
  end

  // Pattern store write at the current length
  always_ff @(posedge clk_i) begin
    if (step_i && item_i.func == wnm_pkg::FUNC_APPEND && !full) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (len_q == LenW'(i)) begin
          store_q[i] <= item_i.ch;
        end
      end
    end
  end

  // Result on the final name char or an empty name
  always_comb begin
    res_o.emit     = step_i && ((item_i.func == wnm_pkg::FUNC_NAME && item_i.last) ||
                                item_i.func == wnm_pkg::FUNC_EMPTY);
    res_o.overflow = too_long_q;
    res_o.matched  = !too_long_q &&
                     ((item_i.func == wnm_pkg::FUNC_EMPTY) ? hit_empty : hit_name);
  end

endmodule
`default_nettype wire

// File: hdl/wildcard_name_match_unit.sv
// Wildcard file name matcher.
// Input stream: tuser[1:0] selects clear pattern, append pattern char, name
// char or empty name; tdata[7:0] is the char; tlast marks the final name char.
// A star matches any run, a question mark one char; name chars are folded
// to upper case (a-z plus sixteen accented pairs from the fold registers).
// Output stream: one word per final name char or empty name, tdata[0] is
// the match, tdata[1] says the pattern was longer than PATTERN_MAX.
// A word is taken into the input register when accepted, stepped through
// the position-set logic once the output register is free, and a final-char
// or empty-name result is then registered in the output register.
// Throughput: one word per cycle unless the receiver stalls; the position-set
// update is a single pass over all pattern lanes with one carry add for star runs.
// Reset clears pattern, flags and the fold registers. If the receiver
// stalls while a result is pending, the input register fills and tready
// drops; nothing is lost. Fold registers are written over APB at byte
// addresses 0, 8, 16, 24, by the user only while the stream is idle; not enforced.
`default_nettype none
`include "wildcard_name_match_unit_macros.svh"
module wildcard_name_match_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  wnm_pkg::fold_cfg_t cfg_q;
  wnm_pkg::item_t     in_item;
  wnm_pkg::item_t     pipe_q;
  wnm_pkg::res_t      res;
  logic [7:0]         folded_ch;
  logic               pipe_valid_q;
  logic               out_valid_q;
  logic [1:0]         out_data_q;
  logic               in_acc;
  logic               advance;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        wnm_pkg::REG_FOLD_LOWER_A: cfg_q.lower_a <= pwdata;
        wnm_pkg::REG_FOLD_LOWER_B: cfg_q.lower_b <= pwdata;
        wnm_pkg::REG_FOLD_UPPER_A: cfg_q.upper_a <= pwdata;
        wnm_pkg::REG_FOLD_UPPER_B: cfg_q.upper_b <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      wnm_pkg::REG_FOLD_LOWER_A: prdata = cfg_q.lower_a;
      wnm_pkg::REG_FOLD_LOWER_B: prdata = cfg_q.lower_b;
      wnm_pkg::REG_FOLD_UPPER_A: prdata = cfg_q.upper_a;
      wnm_pkg::REG_FOLD_UPPER_B: prdata = cfg_q.upper_b;
      default:                   prdata = '0;
    endcase
  end

  // Case folding ahead of the input register
  wnm_fold u_fold (
    .cfg_i (cfg_q),
    .ch_i  (s_axis_tdata),
    .ch_o  (folded_ch)
  );

  always_comb begin
    in_item.func = wnm_pkg::func_e'(s_axis_tuser);
    in_item.last = s_axis_tlast;
    in_item.ch   = (in_item.func == wnm_pkg::FUNC_NAME) ? folded_ch : s_axis_tdata;
  end

  // Handshake: the stored word moves on when the output register is free
  assign advance       = pipe_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pipe_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else if (in_acc) begin
      pipe_valid_q <= 1'b1;
    end else if (advance) begin
      pipe_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pipe_q <= in_item;
    end
  end

  // Pattern store and active-position set
  wnm_nfa #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_nfa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (pipe_q),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_data_q <= {res.overflow, res.matched};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_data_q};

  // Checks
  `WNM_ASSERT(a_no_overrun, out_valid_q && !m_axis_tready && pipe_valid_q |-> !s_axis_tready, "overrun")
  `WNM_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(pipe_valid_q), "result without word")
  `WNM_ASSERT(a_overflow_nomatch, m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0], "overflow match")

endmodule
`default_nettype wire
